>>> rtl/one_shot_timer_table_defines.svh
// Assertion macros used by the timer table sequencer.
`ifndef ONE_SHOT_TIMER_TABLE_DEFINES_SVH
`define ONE_SHOT_TIMER_TABLE_DEFINES_SVH

// Check that a condition implies another in the same cycle.
`define OSTT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check that a condition implies another in the next cycle.
`define OSTT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/ostt_pkg.sv
// Shared types and constants of the one-shot timer table.
`timescale 1ns / 1ps
`default_nettype none

package ostt_pkg;

  // Table geometry
  localparam int EVENTS     = 64;
  localparam int DELAY_BITS = 32;
  localparam int IDX_W      = $clog2(EVENTS);

  // Port field widths
  localparam int CMD_W    = 2;
  localparam int ID_W     = 6;
  localparam int DLY_IN_W = 32;
  localparam int KIND_W   = 2;
  localparam int PERIOD_W = 32;
  localparam int CFG_IDX_W = 1;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SET   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FLUSH = 2'd2;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_ACCEPT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REJECT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EXPIRE = 2'd2;
  localparam logic [KIND_W-1:0] KIND_FLUSH  = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TICK_PERIOD    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIMERS_ENABLED = 1'd1;

  // Configuration seen by the sequencer
  typedef struct packed {
    logic [PERIOD_W-1:0] tick_period;
    logic                enabled;
  } cfg_t;

endpackage

`default_nettype wire

>>> rtl/ostt_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module ostt_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; hold the last word when idle
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/ostt_ctrl.sv
// Sequencer of the timer table: set handling, tick and flush sweeps, result register.
`timescale 1ns / 1ps
`default_nettype none
`include "one_shot_timer_table_defines.svh"

module ostt_ctrl (
  input  logic                            clk,
  input  logic                            rst,
  input  ostt_pkg::cfg_t                  cfg,
  input  logic                            cmd_valid,
  output logic                            cmd_stall,
  input  logic [ostt_pkg::CMD_W-1:0]      cmd,
  input  logic [ostt_pkg::ID_W-1:0]       event_id,
  input  logic [ostt_pkg::DLY_IN_W-1:0]   delay,
  output logic                            res_valid,
  input  logic                            res_stall,
  output logic [ostt_pkg::KIND_W-1:0]     kind,
  output logic [ostt_pkg::ID_W-1:0]       result_id,
  output logic                            is_new,
  output logic                            last,
  output logic                            ram_we,
  output logic [ostt_pkg::IDX_W-1:0]      ram_waddr,
  output logic [ostt_pkg::DELAY_BITS-1:0] ram_wdata,
  output logic                            ram_re,
  output logic [ostt_pkg::IDX_W-1:0]      ram_raddr,
  input  logic [ostt_pkg::DELAY_BITS-1:0] ram_rdata
);

  import ostt_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SET  = 4'b0010,
    S_SCAN = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  localparam logic [IDX_W:0] SCAN_END = (IDX_W+1)'(EVENTS);

  state_t              state;
  logic                op_flush;
  logic [ID_W-1:0]     sid;
  logic                sid_ok;
  logic [DELAY_BITS-1:0] sdelay;
  logic [IDX_W:0]      ridx;
  logic [IDX_W-1:0]    pidx;
  logic                pv;
  logic [EVENTS-1:0]   armed;
  logic                hold_valid;
  logic [IDX_W-1:0]    hold_id;

  logic                accept;
  logic                out_can_load;
  logic [IDX_W-1:0]    sidx;
  logic                s_armed;
  logic                p_armed;
  logic                expire;
  logic                need_emit;
  logic                proceed;
  logic                at_end;

  logic                push;
  logic [KIND_W-1:0]   push_kind;
  logic [ID_W-1:0]     push_id;
  logic                push_new;
  logic                push_last;

  logic                arm_we;
  logic [IDX_W-1:0]    arm_idx;
  logic                arm_val;

  // Handshake and shared decode
  assign cmd_stall    = (state != S_IDLE);
  assign accept       = cmd_valid && !cmd_stall;
  assign out_can_load = !res_valid || !res_stall;
  assign sidx         = IDX_W'(sid);
  assign s_armed      = armed[sidx];
  assign p_armed      = armed[pidx];
  assign expire       = 64'(ram_rdata) <= 64'(cfg.tick_period);
  assign need_emit    = (state == S_SCAN) && pv && p_armed && (op_flush || expire);
  assign proceed      = !(need_emit && hold_valid && !out_can_load);
  assign at_end       = (ridx == SCAN_END);

  // Decide memory traffic, armed-bit updates and result pushes
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = sidx;
    ram_wdata = sdelay;
    ram_re    = 1'b0;
    ram_raddr = IDX_W'(event_id);
    arm_we    = 1'b0;
    arm_idx   = sidx;
    arm_val   = 1'b0;
    push      = 1'b0;
    push_kind = KIND_REJECT;
    push_id   = sid;
    push_new  = 1'b0;
    push_last = 1'b1;
    case (state)
      S_IDLE: begin
        // fetch the addressed slot for a set
        ram_re = accept && (cmd == CMD_SET);
      end
      S_SET: begin
        if (out_can_load) begin
          push = 1'b1;
          if (cfg.enabled && sid_ok) begin
            if (!s_armed) begin
              if (sdelay != '0) begin
                ram_we    = 1'b1;
                arm_we    = 1'b1;
                arm_val   = 1'b1;
                push_kind = KIND_ACCEPT;
                push_new  = 1'b1;
              end
            end else begin
              push_kind = KIND_ACCEPT;
              if (sdelay == '0) begin
                arm_we = 1'b1;
              end else if (ram_rdata < sdelay) begin
                ram_we = 1'b1;
              end
            end
          end
        end
      end
      S_SCAN: begin
        if (proceed) begin
          // retire or age the entry whose data is on the read port
          if (pv && p_armed) begin
            arm_idx = pidx;
            if (need_emit) begin
              arm_we = 1'b1;
            end else begin
              ram_we    = 1'b1;
              ram_waddr = pidx;
              ram_wdata = ram_rdata - DELAY_BITS'(cfg.tick_period);
            end
          end
          // pass the held result on once a later one is known
          if (need_emit && hold_valid) begin
            push      = 1'b1;
            push_kind = op_flush ? KIND_FLUSH : KIND_EXPIRE;
            push_id   = ID_W'(hold_id);
            push_last = 1'b0;
          end
          if (!at_end) begin
            ram_re    = 1'b1;
            ram_raddr = ridx[IDX_W-1:0];
          end
        end
      end
      S_FIN: begin
        if (hold_valid && out_can_load) begin
          push      = 1'b1;
          push_kind = op_flush ? KIND_FLUSH : KIND_EXPIRE;
          push_id   = ID_W'(hold_id);
        end
      end
      default: begin
      end
    endcase
  end

  // Sequencer state and sweep pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      pv         <= 1'b0;
      hold_valid <= 1'b0;
      ridx       <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (cmd == CMD_SET) begin
              state <= S_SET;
            end else if ((cmd == CMD_FLUSH) || ((cmd == CMD_TICK) && cfg.enabled)) begin
              state      <= S_SCAN;
              ridx       <= '0;
              pv         <= 1'b0;
              hold_valid <= 1'b0;
            end
          end
        end
        S_SET: begin
          if (out_can_load) begin
            state <= S_IDLE;
          end
        end
        S_SCAN: begin
          if (proceed) begin
            if (need_emit) begin
              hold_valid <= 1'b1;
            end
            if (!at_end) begin
              pv   <= 1'b1;
              ridx <= ridx + 1'b1;
            end else begin
              pv <= 1'b0;
              if (!pv) begin
                state <= S_FIN;
              end
            end
          end
        end
        S_FIN: begin
          if (!hold_valid || out_can_load) begin
            hold_valid <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Latch command operands and the held result id
  always_ff @(posedge clk) begin
    if (accept) begin
      op_flush <= (cmd == CMD_FLUSH);
      sid      <= event_id;
      sid_ok   <= (32'(event_id) < 32'(EVENTS));
      sdelay   <= DELAY_BITS'(delay);
    end
    if ((state == S_SCAN) && proceed) begin
      if (!at_end) begin
        pidx <= ridx[IDX_W-1:0];
      end
      if (need_emit) begin
        hold_id <= pidx;
      end
    end
  end

  // Armed bits, cleared together at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      armed <= '0;
    end else if (arm_we) begin
      armed[arm_idx] <= arm_val;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (push) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      kind      <= push_kind;
      result_id <= push_id;
      is_new    <= push_new;
      last      <= push_last;
    end
  end

  `OSTT_ASSERT_NOW(a_no_addr_clash, ram_we && ram_re, ram_waddr != ram_raddr, "read and write hit the same slot")
  `OSTT_ASSERT_NOW(a_pipe_index, pv, ((IDX_W+1)'(pidx) + 1'b1) == ridx, "sweep pointers out of step")
  `OSTT_ASSERT_NOW(a_hold_in_sweep, hold_valid, (state == S_SCAN) || (state == S_FIN), "held result outside sweep")
  `OSTT_ASSERT_NEXT(a_set_done, (state == S_SET) && out_can_load, state == S_IDLE, "set did not finish")
  `OSTT_ASSERT_NOW(a_new_is_accept, res_valid && is_new, kind == KIND_ACCEPT, "new flag on a non-accept result")

endmodule

`default_nettype wire

>>> rtl/one_shot_timer_table.sv
// Top level of the one-shot timer table: configuration registers and table instances.
//
// Command channel (cmd_valid / cmd_stall) carries cmd, event_id and delay; a word is
// taken at an edge with cmd_valid high and cmd_stall low. Result channel (res_valid /
// res_stall) carries kind, result_id, is_new and last; last marks the final result of
// a command. Configuration writes (cfg_valid / cfg_ready, cfg_index, cfg_data) are
// always ready and must only be issued while the block is idle.
// A set returns exactly one result, loaded from the S_SET state once the result register
// is free, and frees the command channel as it loads that result.
// A tick or a flush sweeps the timer memory one slot per cycle, except while a pending
// result waits on res_stall, through its single read port and holds the command channel
// for the whole sweep; a disabled tick or the unused command code gives no result.
// One command is worked on at a time; cmd_stall stays high until its last result has
// been loaded into the result register.
// Reset clears every armed bit at once, sets tick_period to 1 and disables the
// service; the delay memory needs no clearing pass. While res_stall is high the
// result register holds, one further result is held inside, and the sweep pauses at the next result to emit.
`timescale 1ns / 1ps
`default_nettype none

module one_shot_timer_table (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ostt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ostt_pkg::PERIOD_W-1:0]    cfg_data,
  input  logic                             cmd_valid,
  output logic                             cmd_stall,
  input  logic [ostt_pkg::CMD_W-1:0]       cmd,
  input  logic [ostt_pkg::ID_W-1:0]        event_id,
  input  logic [ostt_pkg::DLY_IN_W-1:0]    delay,
  output logic                             res_valid,
  input  logic                             res_stall,
  output logic [ostt_pkg::KIND_W-1:0]      kind,
  output logic [ostt_pkg::ID_W-1:0]        result_id,
  output logic                             is_new,
  output logic                             last
);

  import ostt_pkg::*;

  logic [PERIOD_W-1:0]   tick_period;
  logic                  timers_enabled;
  cfg_t                  cfg;

  logic                  ram_we;
  logic [IDX_W-1:0]      ram_waddr;
  logic [DELAY_BITS-1:0] ram_wdata;
  logic                  ram_re;
  logic [IDX_W-1:0]      ram_raddr;
  logic [DELAY_BITS-1:0] ram_rdata;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_period    <= PERIOD_W'(1);
      timers_enabled <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_TICK_PERIOD: begin
          tick_period <= cfg_data;
        end
        REG_TIMERS_ENABLED: begin
          timers_enabled <= cfg_data[0];
        end
        default: begin
        end
      endcase
    end
  end

  assign cfg.tick_period = tick_period;
  assign cfg.enabled     = timers_enabled;

  // Sequencer
  ostt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .event_id  (event_id),
    .delay     (delay),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .kind      (kind),
    .result_id (result_id),
    .is_new    (is_new),
    .last      (last),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  // Remaining-time memory
  ostt_ram #(
    .DEPTH (EVENTS),
    .WIDTH (DELAY_BITS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

`default_nettype wire

>>> tb/one_shot_timer_table_checker.sv
// Checker for the one-shot timer table: mirrors the timer store and checks every result word.
`timescale 1ns / 1ps

module one_shot_timer_table_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [ostt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ostt_pkg::PERIOD_W-1:0]  cfg_data,
  input  logic                           cmd_valid,
  input  logic                           cmd_stall,
  input  logic [ostt_pkg::CMD_W-1:0]     cmd,
  input  logic [ostt_pkg::ID_W-1:0]      event_id,
  input  logic [ostt_pkg::DLY_IN_W-1:0]  delay,
  input  logic                           res_valid,
  input  logic                           res_stall,
  input  logic [ostt_pkg::KIND_W-1:0]    kind,
  input  logic [ostt_pkg::ID_W-1:0]      result_id,
  input  logic                           is_new,
  input  logic                           last,
  output int                             fail_count,
  output int                             outstanding
);
  import ostt_pkg::*;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ID_W-1:0]   id;
    logic              is_new;
    logic              last;
  } timer_note_t;

  // Result words still to come, oldest first
  timer_note_t           due_notes[$];
  logic [DELAY_BITS-1:0] time_left [EVENTS];
  logic                  slot_armed [EVENTS];
  logic [PERIOD_W-1:0]   period_ms;
  logic                  service_on;

  // Arm, extend or cancel one slot; a set always answers with exactly one word
  task automatic apply_set(input logic [ID_W-1:0] id, input logic [DLY_IN_W-1:0] dly);
    timer_note_t           note;
    logic [DELAY_BITS-1:0] want;
    want        = dly[DELAY_BITS-1:0];
    note.kind   = KIND_REJECT;
    note.id     = id;
    note.is_new = 1'b0;
    note.last   = 1'b1;
    if (service_on && id < EVENTS) begin
      if (!slot_armed[id]) begin
        // an idle slot takes any nonzero delay; zero is turned away
        if (want != '0) begin
          slot_armed[id] = 1'b1;
          time_left[id]  = want;
          note.is_new    = 1'b1;
          note.kind      = KIND_ACCEPT;
        end
      end else begin
        // zero cancels, a longer delay extends, a shorter one changes nothing
        if (want == '0) begin
          slot_armed[id] = 1'b0;
          time_left[id]  = '0;
        end else if (time_left[id] < want) begin
          time_left[id] = want;
        end
        note.kind = KIND_ACCEPT;
      end
    end
    due_notes.insert(due_notes.size(), note);
  endtask

  // Visit slots in id order: expire or age them on a tick, cancel all on a flush
  task automatic apply_sweep(input logic flushing);
    timer_note_t note;
    int          final_slot;
    final_slot = -1;
    for (int i = 0; i < EVENTS; i++) begin
      if (slot_armed[i] && (flushing || time_left[i] <= period_ms)) final_slot = i;
    end
    for (int i = 0; i < EVENTS; i++) begin
      if (slot_armed[i] && (flushing || time_left[i] <= period_ms)) begin
        note.kind   = flushing ? KIND_FLUSH : KIND_EXPIRE;
        note.id     = ID_W'(i);
        note.is_new = 1'b0;
        note.last   = (i == final_slot);
        due_notes.insert(due_notes.size(), note);
        slot_armed[i] = 1'b0;
        time_left[i]  = '0;
      end else if (slot_armed[i]) begin
        time_left[i] = time_left[i] - period_ms;
      end
    end
  endtask

  always @(posedge clk) begin
    timer_note_t due;
    if (rst) begin
      due_notes.delete();
      for (int i = 0; i < EVENTS; i++) begin
        time_left[i]  = '0;
        slot_armed[i] = 1'b0;
      end
      period_ms  = PERIOD_W'(1);
      service_on = 1'b0;
    end else begin
      // Track register writes
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_TICK_PERIOD) begin
          period_ms = cfg_data;
        end else if (cfg_index == REG_TIMERS_ENABLED) begin
          service_on = cfg_data[0];
        end
      end

      // Predict the words caused by an accepted command
      if (cmd_valid && !cmd_stall) begin
        case (cmd)
          CMD_TICK: begin
            if (service_on) apply_sweep(1'b0);
          end
          CMD_SET: begin
            apply_set(event_id, delay);
          end
          CMD_FLUSH: begin
            apply_sweep(1'b1);
          end
          default: begin
          end
        endcase
      end

      // Compare an accepted result word with the oldest prediction
      if (res_valid && !res_stall) begin
        if (due_notes.size() == 0) begin
          $error("unexpected result word: kind %0d, result_id %0d", kind, result_id);
          fail_count++;
        end else begin
          due = due_notes.pop_front();
          if (kind !== due.kind) begin
            $error("kind: expected %0d, got %0d", due.kind, kind);
            fail_count++;
          end
          if (result_id !== due.id) begin
            $error("result_id: expected %0d, got %0d", due.id, result_id);
            fail_count++;
          end
          if (is_new !== due.is_new) begin
            $error("is_new: expected %0d, got %0d", due.is_new, is_new);
            fail_count++;
          end
          if (last !== due.last) begin
            $error("last: expected %0d, got %0d", due.last, last);
            fail_count++;
          end
        end
      end
    end
    outstanding <= due_notes.size();
  end

endmodule

>>> tb/tb_one_shot_timer_table.sv
// Testbench top for the one-shot timer table: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_one_shot_timer_table;
  import ostt_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int LONG_HOLD   = 300;
  localparam int SWEEP_SLACK = EVENTS + 8;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_TICK_PERIOD;
  logic [PERIOD_W-1:0]  cfg_data  = '0;
  logic                 cmd_valid = 1'b0;
  logic                 cmd_stall;
  logic [CMD_W-1:0]     cmd       = CMD_TICK;
  logic [ID_W-1:0]      event_id  = '0;
  logic [DLY_IN_W-1:0]  delay     = '0;
  logic                 res_valid;
  logic                 res_stall = 1'b0;
  logic [KIND_W-1:0]    kind;
  logic [ID_W-1:0]      result_id;
  logic                 is_new;
  logic                 last;
  int                   fail_count;
  int                   outstanding;

  logic [PERIOD_W-1:0]  period_now   = PERIOD_W'(1);
  logic                 sender_gaps  = 1'b1;
  logic                 hold_request = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  one_shot_timer_table u_dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd(cmd), .event_id(event_id),
    .delay(delay),
    .res_valid(res_valid), .res_stall(res_stall), .kind(kind), .result_id(result_id),
    .is_new(is_new), .last(last)
  );

  one_shot_timer_table_checker u_check (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd(cmd), .event_id(event_id),
    .delay(delay),
    .res_valid(res_valid), .res_stall(res_stall), .kind(kind), .result_id(result_id),
    .is_new(is_new), .last(last),
    .fail_count(fail_count), .outstanding(outstanding)
  );

  // Offer one command word after an optional gap and hold it until taken
  task automatic send_word(input logic [CMD_W-1:0] c, input logic [ID_W-1:0] id,
                           input logic [DLY_IN_W-1:0] dly);
    int gap;
    int r;
    gap = 0;
    r   = $urandom_range(0, 99);
    if (sender_gaps) begin
      if (r >= 90) gap = $urandom_range(10, 60);
      else if (r >= 50) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd       <= c;
    event_id  <= id;
    delay     <= dly;
    do @(posedge clk); while (cmd_stall);
  endtask

  // Drop valid, wait for every outstanding word, then let a silent sweep finish
  task automatic settle();
    cmd_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SWEEP_SLACK) @(posedge clk);
  endtask

  // Write both registers while the block is idle
  task automatic set_config(input logic [PERIOD_W-1:0] period, input logic enable);
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= REG_TICK_PERIOD;
    cfg_data  <= period;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= REG_TIMERS_ENABLED;
    cfg_data  <= PERIOD_W'(enable);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid  <= 1'b0;
    period_now  = period;
  endtask

  // Mostly sets with delays of a few periods, so timers age, extend and expire
  task automatic random_phase(input int count);
    int                  r;
    logic [63:0]         span;
    logic [ID_W-1:0]     id;
    logic [DLY_IN_W-1:0] dly;
    for (int n = 0; n < count; n++) begin
      if (n % 15 == 0) sender_gaps = ($urandom_range(0, 3) != 0);
      r  = $urandom_range(0, 99);
      id = ($urandom_range(0, 1) != 0) ? ID_W'($urandom_range(0, 11)) : ID_W'($urandom);
      case ($urandom_range(0, 9))
        0: dly = '0;
        1, 2: dly = $urandom;
        3: dly = ($urandom_range(0, 1) != 0) ? '1 : DLY_IN_W'(1);
        default: begin
          span = 64'(period_now) * $urandom_range(1, 5) + $urandom_range(0, 2);
          if (span == 0) span = $urandom_range(1, 50);
          dly = (span > 64'hFFFF_FFFF) ? '1 : span[DLY_IN_W-1:0];
        end
      endcase
      if (r < 62) send_word(CMD_SET, id, dly);
      else if (r < 88) send_word(CMD_TICK, id, dly);
      else if (r < 94) send_word(CMD_FLUSH, id, dly);
      else send_word(CMD_UNUSED, id, dly);
    end
    sender_gaps = 1'b1;
  endtask

  // Result side: random stalls, quiet stretches and one long hold on request
  initial begin
    int run;
    int r;
    @(posedge clk);
    forever begin
      r = $urandom_range(0, 99);
      if (hold_request) begin
        hold_request = 1'b0;
        res_stall <= 1'b1;
        run = LONG_HOLD;
      end else if (r < 40) begin
        res_stall <= 1'b0;
        run = $urandom_range(1, 4);
      end else if (r < 70) begin
        res_stall <= 1'b1;
        run = $urandom_range(1, 3);
      end else if (r < 90) begin
        res_stall <= 1'b0;
        run = $urandom_range(20, 80);
      end else begin
        res_stall <= 1'b1;
        run = $urandom_range(8, 30);
      end
      repeat (run) @(posedge clk);
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Service off after reset: set rejected, tick silent, empty flush, unused code
    send_word(CMD_SET, 6'd5, 32'd10);
    send_word(CMD_TICK, 6'd0, 32'd0);
    send_word(CMD_FLUSH, 6'd0, 32'd0);
    send_word(CMD_UNUSED, 6'd9, 32'd3);

    // Arm, reject, cancel, keep and extend
    set_config(32'd1, 1'b1);
    send_word(CMD_SET, 6'd0, 32'd0);
    send_word(CMD_SET, 6'd0, 32'd1);
    send_word(CMD_SET, 6'd63, 32'hFFFF_FFFF);
    send_word(CMD_SET, 6'd0, 32'd0);
    send_word(CMD_SET, 6'd10, 32'd5);
    send_word(CMD_SET, 6'd10, 32'd3);
    send_word(CMD_SET, 6'd10, 32'd5);
    send_word(CMD_SET, 6'd10, 32'd8);
    send_word(CMD_SET, 6'd1, 32'd1);
    send_word(CMD_TICK, 6'd0, 32'd0);
    send_word(CMD_TICK, 6'd0, 32'd0);
    send_word(CMD_UNUSED, 6'd63, 32'hFFFF_FFFF);
    send_word(CMD_SET, 6'd42, 32'h8000_0000);
    send_word(CMD_SET, 6'd21, 32'h7FFF_FFFF);

    // Zero period: nothing ages or expires
    set_config(32'd0, 1'b1);
    send_word(CMD_TICK, 6'd0, 32'd0);

    // Service off with armed timers: tick silent, set rejected, flush still works
    set_config(32'hFFFF_FFFF, 1'b0);
    send_word(CMD_TICK, 6'd0, 32'd0);
    send_word(CMD_SET, 6'd30, 32'd4);
    send_word(CMD_FLUSH, 6'd0, 32'd0);

    // Largest period expires everything on one tick
    set_config(32'hFFFF_FFFF, 1'b1);
    send_word(CMD_SET, 6'd7, 32'd100);
    send_word(CMD_SET, 6'd50, 32'hFFFF_FFFF);
    send_word(CMD_TICK, 6'd0, 32'd0);

    // Fill the table, hold the result side and keep offering words behind a full tick
    set_config(32'd4, 1'b1);
    for (int i = 0; i < EVENTS; i++) send_word(CMD_SET, ID_W'(i), DLY_IN_W'($urandom_range(1, 4)));
    cmd_valid <= 1'b0;
    hold_request = 1'b1;
    while (hold_request) @(posedge clk);
    send_word(CMD_TICK, 6'd0, 32'd0);
    for (int i = 0; i < 12; i++) send_word(CMD_SET, ID_W'($urandom), $urandom);
    settle();

    // Full table again, cleared by one flush
    for (int i = 0; i < EVENTS; i++) send_word(CMD_SET, ID_W'(i), $urandom);
    send_word(CMD_FLUSH, 6'd0, 32'd0);

    // Random traffic under a range of settings
    set_config(32'd1, 1'b1);
    random_phase(30);
    set_config(32'd7, 1'b1);
    random_phase(25);
    set_config($urandom | 32'h8000_0000, 1'b1);
    random_phase(15);
    set_config(32'd0, 1'b1);
    random_phase(10);
    set_config(PERIOD_W'($urandom_range(2, 50)), 1'b0);
    random_phase(10);
    set_config(32'd3, 1'b1);
    random_phase(25);

    settle();
    if (fail_count == 0) begin
      $display("tb_one_shot_timer_table passed");
    end else begin
      $display("tb_one_shot_timer_table failed");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #30_000_000;
    $display("tb_one_shot_timer_table failed");
    $finish;
  end

endmodule
